// File: rtl/srpg_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the stepper ramp pulse generator.
// No dependencies; imported by every other file of the block.
package srpg_pkg;

  // Fixed-point constants
  localparam int unsigned Q16_ONE    = 65536;
  localparam int unsigned STOP_SPEED = 16384;
  localparam int unsigned PHASE_MAX  = 262143;

  // Bit-serial divider geometry: dividend up to accel << 16, divisor the tick rate
  localparam int unsigned DIV_NW = 36;
  localparam int unsigned DIV_DW = 20;
  localparam int unsigned DIV_CW = 6;

  // Configuration port address width
  localparam int unsigned APB_AW = 5;

  // Command codes of an input request
  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_SET_TARGET = 2'd1,
    CMD_REZERO     = 2'd2
  } cmd_e;

  // Register indexes
  typedef enum logic [2:0] {
    REG_MAX_SPEED   = 3'd0,
    REG_ACCEL       = 3'd1,
    REG_TICK_RATE   = 3'd2,
    REG_HARD_LIMIT  = 3'd3,
    REG_DIR_SETUP   = 3'd4,
    REG_STEP_HIGH   = 3'd5,
    REG_STEP_ACTIVE = 3'd6,
    REG_DIR_INV     = 3'd7
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_MUL,
    ST_DIVD,
    ST_VEL,
    ST_DIVP,
    ST_STEP,
    ST_DONE
  } state_e;

  // Configuration handed from the register file to the core
  typedef struct packed {
    logic [14:0] max_speed;
    logic [19:0] accel;
    logic [19:0] tick_rate;
    logic [22:0] hard_limit;
    logic [15:0] dir_setup;
    logic [15:0] step_high;
    logic        step_active_high;
    logic        dir_inverted;
  } srpg_cfg_t;

endpackage

// File: rtl/srpg_div.sv
`timescale 1ns / 1ps
// Restoring divider that retires one quotient bit per cycle.
// Depends on srpg_pkg for its widths.
module srpg_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [srpg_pkg::DIV_NW-1:0]  dividend_i,
  input  logic [srpg_pkg::DIV_DW-1:0]  divisor_i,
  output logic                         done_o,
  output logic [srpg_pkg::DIV_NW-1:0]  quotient_o
);
  import srpg_pkg::*;

  logic              busy_q, busy_d, done_q, done_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [DIV_DW-1:0] rem_q, rem_d, div_q, div_d;
  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [DIV_DW:0]   trial, diff;
  logic              ge;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign trial = {rem_q, quo_q[DIV_NW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      div_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      quo_d = {quo_q[DIV_NW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state is reset; the data path is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/srpg_regs.sv
`timescale 1ns / 1ps
// APB-style configuration register file of the stepper pulse generator.
// Depends on srpg_pkg for the register indexes and the configuration struct.
module srpg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [srpg_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output srpg_pkg::srpg_cfg_t          cfg_o
);
  import srpg_pkg::*;

  srpg_cfg_t cfg_q, cfg_d;
  reg_idx_e  idx;
  logic      wr_en;

  assign idx   = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_en = psel & penable & pwrite;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_MAX_SPEED:   cfg_d.max_speed        = pwdata[14:0];
        REG_ACCEL:       cfg_d.accel            = pwdata[19:0];
        REG_TICK_RATE:   cfg_d.tick_rate        = pwdata[19:0];
        REG_HARD_LIMIT:  cfg_d.hard_limit       = pwdata[22:0];
        REG_DIR_SETUP:   cfg_d.dir_setup        = pwdata[15:0];
        REG_STEP_HIGH:   cfg_d.step_high        = pwdata[15:0];
        REG_STEP_ACTIVE: cfg_d.step_active_high = pwdata[0];
        REG_DIR_INV:     cfg_d.dir_inverted     = pwdata[0];
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    unique case (idx)
      REG_MAX_SPEED:   prdata = {17'd0, cfg_q.max_speed};
      REG_ACCEL:       prdata = {12'd0, cfg_q.accel};
      REG_TICK_RATE:   prdata = {12'd0, cfg_q.tick_rate};
      REG_HARD_LIMIT:  prdata = {9'd0, cfg_q.hard_limit};
      REG_DIR_SETUP:   prdata = {16'd0, cfg_q.dir_setup};
      REG_STEP_HIGH:   prdata = {16'd0, cfg_q.step_high};
      REG_STEP_ACTIVE: prdata = {31'd0, cfg_q.step_active_high};
      REG_DIR_INV:     prdata = {31'd0, cfg_q.dir_inverted};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_speed        <= 15'd2000;
      cfg_q.accel            <= 20'd10000;
      cfg_q.tick_rate        <= 20'd20000;
      cfg_q.hard_limit       <= 23'd8000;
      cfg_q.dir_setup        <= 16'd2;
      cfg_q.step_high        <= 16'd1;
      cfg_q.step_active_high <= 1'b1;
      cfg_q.dir_inverted     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/stepper_ramp_pulse_generator.sv
`timescale 1ns / 1ps
// Stepper ramp pulse generator: trapezoidal velocity profile with STEP/DIR output.
// Set-target, rezero and short ticks go from the command state straight to the result
// state; a full motion tick first takes a pass through the shared bit-serial divider for
// the velocity step and, while the motor moves, a second pass for the phase step.
// One request is processed at a time; the next is taken while a result waits.
// Reset is asynchronous and active low; it restores every control and motion state register.
module stepper_ramp_pulse_generator #(
  parameter int unsigned POSITION_WIDTH = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [srpg_pkg::APB_AW-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        cmd_i,
  input  logic signed [POSITION_WIDTH-1:0]  target_position_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              step_level_o,
  output logic                              dir_level_o,
  output logic signed [POSITION_WIDTH-1:0]  position_steps_o,
  output logic signed [31:0]                velocity_fixed_o,
  output logic                              fault_flag_o,
  output logic                              zero_accepted_o
);
  import srpg_pkg::*;

  localparam int unsigned PW   = POSITION_WIDTH;
  localparam int unsigned CW   = (PW + 2 > 25) ? PW + 2 : 25;
  localparam int unsigned PRW  = PW + 21;
  localparam int unsigned CMPW = ((PRW > 32) ? PRW : 32) + 1;

  srpg_cfg_t cfg;

  // Configuration registers
  srpg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );
  assign pready = 1'b1;

  // Shared divider
  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_dividend, div_quo;
  logic [DIV_DW-1:0] hz_eff;

  srpg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (hz_eff),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  state_e          state_q, state_d;
  cmd_e            cmd_q, cmd_d;
  logic [PW-1:0]   tgt_q, tgt_d;
  logic [PW-1:0]   goal_q, goal_d, pos_q, pos_d;
  logic [31:0]     vel_q, vel_d;
  logic [17:0]     phase_q, phase_d;
  logic            heading_neg_q, heading_neg_d;
  logic [15:0]     setup_q, setup_d, pulse_q, pulse_d;
  logic            fault_q, fault_d, step_pin_q, step_pin_d, dir_pin_q, dir_pin_d;
  logic            want_nz_q, want_nz_d, want_neg_q, want_neg_d, zero_ok_q, zero_ok_d;
  logic [31:0]     spd2_q, spd2_d;
  logic [PRW-1:0]  prod_q, prod_d;
  logic            out_valid_q, out_valid_d, out_load;
  logic            o_step_q, o_dir_q, o_fault_q, o_zero_q;
  logic [PW-1:0]   o_pos_q;
  logic [31:0]     o_vel_q;

  // Effective divisors and magnitudes
  logic [19:0]     acc_eff;
  logic [15:0]     step_len;
  logic [31:0]     vel_abs;
  logic [15:0]     spd;
  logic [CW-1:0]   pos_ext, goal_ext, err, err_abs, pos_abs, np, np_abs, limit_ext;
  logic            err_neg, err_nz, pos_over, np_over;
  logic [PW-1:0]   errm1;

  assign hz_eff    = (cfg.tick_rate == '0) ? 20'd1 : cfg.tick_rate;
  assign acc_eff   = (cfg.accel == '0) ? 20'd1 : cfg.accel;
  assign step_len  = (cfg.step_high == '0) ? 16'd1 : cfg.step_high;
  assign vel_abs   = vel_q[31] ? (32'd0 - vel_q) : vel_q;
  assign spd       = vel_abs[31:16];
  assign pos_ext   = {{(CW-PW){pos_q[PW-1]}}, pos_q};
  assign goal_ext  = {{(CW-PW){goal_q[PW-1]}}, goal_q};
  assign limit_ext = {{(CW-23){1'b0}}, cfg.hard_limit};
  assign err       = goal_ext - pos_ext;
  assign err_neg   = err[CW-1];
  assign err_nz    = |err;
  assign err_abs   = err_neg ? (CW'(0) - err) : err;
  assign errm1     = PW'(err_abs - CW'(1));
  assign pos_abs   = pos_ext[CW-1] ? (CW'(0) - pos_ext) : pos_ext;
  assign pos_over  = pos_abs > limit_ext;
  assign np        = pos_ext + {{(CW-1){vel_q[31]}}, 1'b1};
  assign np_abs    = np[CW-1] ? (CW'(0) - np) : np;
  assign np_over   = np_abs > limit_ext;

  // Velocity update toward the requested speed, limited by the per-tick delta.
  logic               stop_hit;
  logic signed [37:0] cur38, des38, delta38, diff38, nxt38;
  logic [31:0]        nxt32, vel_next, vel_next_abs;

  assign stop_hit = (vel_q != '0) && (vel_q[31] == want_neg_q) &&
                    ({{(CMPW-32){1'b0}}, spd2_q} > {{(CMPW-PRW){1'b0}}, prod_q});

  always_comb begin
    cur38   = {{6{vel_q[31]}}, vel_q};
    delta38 = {2'b00, div_quo};
    if (!want_nz_q || stop_hit) begin
      des38 = '0;
    end else if (want_neg_q) begin
      des38 = 38'sd0 - $signed({7'd0, cfg.max_speed, 16'd0});
    end else begin
      des38 = $signed({7'd0, cfg.max_speed, 16'd0});
    end
    diff38 = '0;
    nxt38  = cur38;
    if (cur38 < des38) begin
      diff38 = des38 - cur38;
      nxt38  = (diff38 > delta38) ? cur38 + delta38 : des38;
    end else if (cur38 > des38) begin
      diff38 = cur38 - des38;
      nxt38  = (diff38 > delta38) ? cur38 - delta38 : des38;
    end
    nxt32 = nxt38[31:0];
    // A reversal always passes through a tick of zero velocity.
    if ((vel_q != '0) && (nxt32 != '0) && (vel_q[31] != nxt32[31])) begin
      vel_next = '0;
    end else begin
      vel_next = nxt32;
    end
    vel_next_abs = vel_next[31] ? (32'd0 - vel_next) : vel_next;
  end

  // Phase accumulation with saturation.
  logic [36:0] psum;
  logic [17:0] psat;
  assign psum = {19'd0, phase_q} + {1'b0, div_quo};
  assign psat = (psum > 37'(PHASE_MAX)) ? 18'(PHASE_MAX) : psum[17:0];

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_CMD;
      ST_CMD: begin
        if (cmd_q == CMD_TICK && pulse_q == '0 && !fault_q && !pos_over) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_MUL:  state_d = ST_DIVD;
      ST_DIVD: if (div_done) state_d = ST_VEL;
      ST_VEL:  state_d = (vel_next != '0 && want_nz_q) ? ST_DIVP : ST_DONE;
      ST_DIVP: if (div_done) state_d = ST_STEP;
      ST_STEP: state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Data path updates per state.
  always_comb begin
    cmd_d         = cmd_q;
    tgt_d         = tgt_q;
    goal_d        = goal_q;
    pos_d         = pos_q;
    vel_d         = vel_q;
    phase_d       = phase_q;
    heading_neg_d = heading_neg_q;
    setup_d       = setup_q;
    pulse_d       = pulse_q;
    fault_d       = fault_q;
    step_pin_d    = step_pin_q;
    dir_pin_d     = dir_pin_q;
    want_nz_d     = want_nz_q;
    want_neg_d    = want_neg_q;
    zero_ok_d     = zero_ok_q;
    spd2_d        = spd2_q;
    prod_d        = prod_q;
    div_start     = 1'b0;
    div_dividend  = {acc_eff, 16'd0};
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d     = cmd_e'(cmd_i);
          tgt_d     = target_position_i;
          zero_ok_d = 1'b0;
        end
      end
      ST_CMD: begin
        want_nz_d  = err_nz;
        want_neg_d = err_neg;
        spd2_d     = {16'd0, spd} * {16'd0, spd};
        unique case (cmd_q)
          CMD_TICK: begin
            if (pulse_q != '0) begin
              // Pulse in progress: only count it down, and drop the step pin when it ends.
              pulse_d = pulse_q - 16'd1;
              if (pulse_q == 16'd1) step_pin_d = ~cfg.step_active_high;
            end else if (fault_q) begin
              vel_d   = '0;
              phase_d = '0;
            end else if (pos_over) begin
              fault_d    = 1'b1;
              goal_d     = pos_q;
              vel_d      = '0;
              phase_d    = '0;
              step_pin_d = ~cfg.step_active_high;
              pulse_d    = '0;
            end else begin
              div_start = 1'b1;
            end
          end
          CMD_SET_TARGET: goal_d = tgt_q;
          CMD_REZERO: begin
            if (vel_abs < 32'(STOP_SPEED)) begin
              pos_d     = '0;
              goal_d    = '0;
              vel_d     = '0;
              phase_d   = '0;
              fault_d   = 1'b0;
              zero_ok_d = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_MUL: begin
        prod_d = {{21{1'b0}}, errm1} * {{PW{1'b0}}, acc_eff, 1'b0};
      end
      ST_DIVD: ;
      ST_VEL: begin
        vel_d = vel_next;
        if (vel_next == '0 || !want_nz_q) begin
          phase_d = '0;
        end else begin
          div_start    = 1'b1;
          div_dividend = {4'd0, vel_next_abs};
        end
      end
      ST_DIVP: ;
      ST_STEP: begin
        phase_d = psat;
        if (psat[17:16] == 2'b00) begin
          // Less than one whole step accumulated.
        end else if (heading_neg_q != vel_q[31]) begin
          heading_neg_d = vel_q[31];
          dir_pin_d     = ~(vel_q[31] ^ cfg.dir_inverted);
          setup_d       = cfg.dir_setup;
        end else if (setup_q != '0) begin
          setup_d = setup_q - 16'd1;
        end else if (np_over) begin
          fault_d    = 1'b1;
          goal_d     = pos_q;
          vel_d      = '0;
          phase_d    = '0;
          step_pin_d = ~cfg.step_active_high;
          pulse_d    = '0;
        end else begin
          step_pin_d = cfg.step_active_high;
          pulse_d    = step_len;
          pos_d      = np[PW-1:0];
          phase_d    = psat - 18'(Q16_ONE);
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      goal_q        <= '0;
      pos_q         <= '0;
      vel_q         <= '0;
      phase_q       <= '0;
      heading_neg_q <= 1'b0;
      setup_q       <= '0;
      pulse_q       <= '0;
      fault_q       <= 1'b0;
      step_pin_q    <= 1'b0;
      dir_pin_q     <= 1'b1;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      goal_q        <= goal_d;
      pos_q         <= pos_d;
      vel_q         <= vel_d;
      phase_q       <= phase_d;
      heading_neg_q <= heading_neg_d;
      setup_q       <= setup_d;
      pulse_q       <= pulse_d;
      fault_q       <= fault_d;
      step_pin_q    <= step_pin_d;
      dir_pin_q     <= dir_pin_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    tgt_q      <= tgt_d;
    want_nz_q  <= want_nz_d;
    want_neg_q <= want_neg_d;
    zero_ok_q  <= zero_ok_d;
    spd2_q     <= spd2_d;
    prod_q     <= prod_d;
    if (out_load) begin
      o_step_q  <= step_pin_q;
      o_dir_q   <= dir_pin_q;
      o_pos_q   <= pos_q;
      o_vel_q   <= vel_q;
      o_fault_q <= fault_q;
      o_zero_q  <= zero_ok_q;
    end
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign step_level_o     = o_step_q;
  assign dir_level_o      = o_dir_q;
  assign position_steps_o = o_pos_q;
  assign velocity_fixed_o = o_vel_q;
  assign fault_flag_o     = o_fault_q;
  assign zero_accepted_o  = o_zero_q;

endmodule

// File: verif/tb_stepper_ramp_pulse_generator.sv
`timescale 1ns / 1ps
// Self-checking testbench for the stepper ramp pulse generator: directed table, then random phases.
// Depends on srpg_pkg and stepper_ramp_pulse_generator; has its own motion profile predictor.
module tb_stepper_ramp_pulse_generator;
  import srpg_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 2000000;
  localparam int         PHASE_ITEMS = 270;
  localparam int         N_ROWS = 25;
  localparam int         N_PHASES = 6;

  // One result of the block
  typedef struct {
    logic              step;
    logic              dir;
    logic signed [23:0] pos;
    logic signed [31:0] vel;
    logic              fault;
    logic              zero;
  } motion_status_t;

  // One row of the directed table
  typedef struct {
    logic [1:0]         cmd;
    logic signed [23:0] tgt;
    bit                 typed;
    motion_status_t     status;
  } stim_row_t;

  logic               clk_i, rst_ni;
  logic               psel, penable, pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [31:0]        pwdata, prdata;
  logic               pready;
  logic               in_valid_i, in_ready_o;
  logic [1:0]         cmd_i;
  logic signed [23:0] target_position_i;
  logic               out_valid_o, out_ready_i;
  logic               step_level_o, dir_level_o, fault_flag_o, zero_accepted_o;
  logic signed [23:0] position_steps_o;
  logic signed [31:0] velocity_fixed_o;

  stepper_ramp_pulse_generator DUT (.*);

  // Predictor state and configuration shadow
  srpg_cfg_t   cfg;
  longint      goal_pos, cur_pos, cur_vel, phase;
  int          heading;
  int unsigned setup_left, pulse_left;
  bit          fault_on, step_pin, dir_pin;

  motion_status_t pending_status[$];
  motion_status_t table_status[$];
  stim_row_t      rows[N_ROWS];
  int             errors = 0;
  int             cycles = 0;
  bit             calm = 0;
  bit             stall_req = 0;
  bit             expect_typed = 0;

  // Clock
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Run-time limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("stepper_ramp_pulse_generator test failed");
      $finish;
    end
  end

  function automatic int sgn(longint v);
    return v > 0 ? 1 : (v < 0 ? -1 : 0);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint wrap24(longint v);
    logic signed [23:0] t;
    t = v[23:0];
    return longint'(t);
  endfunction

  function automatic void restore_defaults();
    cfg.max_speed = 15'd2000;
    cfg.accel = 20'd10000;
    cfg.tick_rate = 20'd20000;
    cfg.hard_limit = 23'd8000;
    cfg.dir_setup = 16'd2;
    cfg.step_high = 16'd1;
    cfg.step_active_high = 1'b1;
    cfg.dir_inverted = 1'b0;
    goal_pos = 0;
    cur_pos = 0;
    cur_vel = 0;
    phase = 0;
    heading = 1;
    setup_left = 0;
    pulse_left = 0;
    fault_on = 0;
    step_pin = 0;
    dir_pin = 1;
  endfunction

  function automatic void latch_fault();
    fault_on = 1;
    goal_pos = cur_pos;
    cur_vel = 0;
    phase = 0;
    step_pin = !cfg.step_active_high;
    pulse_left = 0;
  endfunction

  // One motion tick of the trapezoidal profile
  function automatic void motion_tick();
    longint hz, acc, lim, err, desired, spd, stop_dist, delta, nxt, np;
    int want, sdir;
    hz = cfg.tick_rate != 0 ? longint'(cfg.tick_rate) : 1;
    acc = cfg.accel != 0 ? longint'(cfg.accel) : 1;
    lim = longint'(cfg.hard_limit);
    if (pulse_left > 0) begin
      pulse_left--;
      if (pulse_left == 0) step_pin = !cfg.step_active_high;
      return;
    end
    if (fault_on) begin
      cur_vel = 0;
      phase = 0;
      return;
    end
    if (mag(cur_pos) > lim) begin
      latch_fault();
      return;
    end
    err = goal_pos - cur_pos;
    want = sgn(err);
    desired = 0;
    if (want != 0) begin
      spd = mag(cur_vel) >>> 16;
      stop_dist = (spd * spd + 2 * acc - 1) / (2 * acc);
      if (!(sgn(cur_vel) == want && stop_dist >= mag(err)))
        desired = longint'(want) * longint'(cfg.max_speed) * 65536;
    end
    delta = (acc * 65536) / hz;
    nxt = cur_vel;
    if (cur_vel < desired) begin
      nxt = (desired - cur_vel > delta) ? cur_vel + delta : desired;
    end else if (cur_vel > desired) begin
      nxt = (cur_vel - desired > delta) ? cur_vel - delta : desired;
    end
    // A reversal passes through zero
    if (sgn(cur_vel) != 0 && sgn(nxt) != 0 && sgn(cur_vel) != sgn(nxt)) nxt = 0;
    cur_vel = nxt;
    if (cur_vel == 0 || want == 0) begin
      phase = 0;
      return;
    end
    sdir = sgn(cur_vel);
    phase += mag(cur_vel) / hz;
    if (phase > PHASE_MAX) phase = PHASE_MAX;
    if (phase < Q16_ONE) return;
    if (heading != sdir) begin
      heading = sdir;
      dir_pin = (sdir > 0) ? !cfg.dir_inverted : cfg.dir_inverted;
      setup_left = cfg.dir_setup;
      return;
    end
    if (setup_left > 0) begin
      setup_left--;
      return;
    end
    np = cur_pos + sdir;
    if (mag(np) > lim) begin
      latch_fault();
      return;
    end
    step_pin = cfg.step_active_high;
    pulse_left = cfg.step_high != 0 ? cfg.step_high : 1;
    cur_pos = wrap24(np);
    phase -= Q16_ONE;
  endfunction

  // Applies one request to the predictor and returns the status that follows
  function automatic motion_status_t predict_status(logic [1:0] cmd, logic signed [23:0] tgt);
    motion_status_t s;
    s.zero = 0;
    case (cmd)
      CMD_TICK: motion_tick();
      CMD_SET_TARGET: goal_pos = longint'(tgt);
      CMD_REZERO: begin
        if (mag(cur_vel) < STOP_SPEED) begin
          cur_pos = 0;
          goal_pos = 0;
          cur_vel = 0;
          phase = 0;
          fault_on = 0;
          s.zero = 1;
        end
      end
      default: ;
    endcase
    s.step = step_pin;
    s.dir = dir_pin;
    s.pos = cur_pos[23:0];
    s.vel = cur_vel[31:0];
    s.fault = fault_on;
    return s;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
    errors++;
  endtask

  // Result check first, then prediction for a newly accepted request
  always @(posedge clk_i) begin
    motion_status_t e, p;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_status.size() == 0) begin
          report_mismatch("unexpected result, position", position_steps_o, 0);
        end else begin
          e = pending_status.pop_front();
          if (step_level_o !== e.step) report_mismatch("step_level", step_level_o, e.step);
          if (dir_level_o !== e.dir) report_mismatch("dir_level", dir_level_o, e.dir);
          if (position_steps_o !== e.pos)
            report_mismatch("position_steps", position_steps_o, e.pos);
          if (velocity_fixed_o !== e.vel)
            report_mismatch("velocity_fixed", velocity_fixed_o, e.vel);
          if (fault_flag_o !== e.fault) report_mismatch("fault_flag", fault_flag_o, e.fault);
          if (zero_accepted_o !== e.zero)
            report_mismatch("zero_accepted", zero_accepted_o, e.zero);
        end
      end
      if (in_valid_i && in_ready_o) begin
        p = predict_status(cmd_i, target_position_i);
        if (expect_typed && table_status.size() != 0) p = table_status.pop_front();
        pending_status.push_back(p);
      end
    end
  end

  // Result side: random back-pressure, one long hold when asked
  initial begin
    int gap;
    out_ready_i = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_req) begin
        stall_req = 0;
        out_ready_i <= 0;
        repeat (400) @(negedge clk_i);
      end else begin
        gap = calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
          out_ready_i <= 0;
          repeat (gap) @(negedge clk_i);
        end
      end
      out_ready_i <= 1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Configuration write: setup cycle then access cycle
  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= APB_AW'(idx) << 2;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_MAX_SPEED: cfg.max_speed = value[14:0];
      REG_ACCEL: cfg.accel = value[19:0];
      REG_TICK_RATE: cfg.tick_rate = value[19:0];
      REG_HARD_LIMIT: cfg.hard_limit = value[22:0];
      REG_DIR_SETUP: cfg.dir_setup = value[15:0];
      REG_STEP_HIGH: cfg.step_high = value[15:0];
      REG_STEP_ACTIVE: cfg.step_active_high = value[0];
      REG_DIR_INV: cfg.dir_inverted = value[0];
      default: ;
    endcase
  endtask

  task automatic write_all(int ms, int ac, int hz, int lim, int su, int hi, int act, int inv);
    write_reg(REG_MAX_SPEED, ms);
    write_reg(REG_ACCEL, ac);
    write_reg(REG_TICK_RATE, hz);
    write_reg(REG_HARD_LIMIT, lim);
    write_reg(REG_DIR_SETUP, su);
    write_reg(REG_STEP_HIGH, hi);
    write_reg(REG_STEP_ACTIVE, act);
    write_reg(REG_DIR_INV, inv);
  endtask

  // Offers one request; starts and ends at a falling edge
  task automatic send_request(logic [1:0] cmd, logic signed [23:0] tgt);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1;
    cmd_i <= cmd;
    target_position_i <= tgt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (pending_status.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  function automatic motion_status_t at_rest(logic zero);
    motion_status_t s;
    s = '{step: 1'b0, dir: 1'b1, pos: '0, vel: '0, fault: 1'b0, zero: zero};
    return s;
  endfunction

  function automatic stim_row_t row(logic [1:0] cmd, int tgt, bit typed, motion_status_t s);
    stim_row_t r;
    r.cmd = cmd;
    r.tgt = 24'(tgt);
    r.typed = typed;
    r.status = s;
    return r;
  endfunction

  // Main sequence
  initial begin
    int ms, ac, hz, lim, su, hi, span, sel;
    logic [1:0] cmd;
    logic signed [23:0] tgt;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 0;
    cmd_i = CMD_TICK;
    target_position_i = '0;
    restore_defaults();
    rst_ni = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed part: a fast profile with a tight hard limit
    write_all(500, 1000000, 100, 5, 1, 1, 1, 0);
    for (int i = 0; i < N_ROWS; i++) rows[i] = row(CMD_TICK, 0, 0, at_rest(0));
    rows[0] = row(CMD_TICK, 0, 1, at_rest(0));
    rows[1] = row(CMD_UNUSED, -1, 1, at_rest(0));
    rows[2] = row(CMD_REZERO, 0, 1, at_rest(1));
    rows[3] = row(CMD_SET_TARGET, 8388607, 1, at_rest(0));
    rows[8] = row(CMD_REZERO, 0, 0, at_rest(0));
    rows[16] = row(CMD_REZERO, 0, 0, at_rest(0));
    rows[17] = row(CMD_SET_TARGET, -8388608, 0, at_rest(0));
    rows[24] = row(CMD_SET_TARGET, 0, 0, at_rest(0));
    for (int i = 0; i < N_ROWS; i++) begin
      // A typed row takes the table's value in place of the predictor's
      expect_typed = rows[i].typed;
      if (rows[i].typed) table_status.push_back(rows[i].status);
      send_request(rows[i].cmd, rows[i].tgt);
      drain();
    end
    expect_typed = 0;

    // Random phases, each under its own settings, extremes among them
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin ms = 32767; ac = 1000000; hz = 1; lim = 8388607; su = 0; hi = 0; end
        1: begin ms = 1; ac = 1; hz = 1000000; lim = 0; su = 65535; hi = 65535; end
        2: begin ms = 300; ac = 0; hz = 0; lim = 20; su = 3; hi = 2; end
        3: begin ms = 2000; ac = 50000; hz = 1000; lim = 30; su = 2; hi = 3; end
        4: begin ms = 800; ac = 200000; hz = 200; lim = 12; su = 0; hi = 1; end
        default: begin ms = 5000; ac = 1000000; hz = 5000; lim = 40; su = 5; hi = 0; end
      endcase
      write_all(ms, ac, hz, lim, su, hi, ph % 2, (ph / 2) % 2);
      calm = (ph % 3 == 1);
      span = lim > 100 ? 100 : lim;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == 60) stall_req = 1;
        if (ph == 4 && n == 135) begin
          in_valid_i <= 0;
          while (pending_status.size() != 0) @(negedge clk_i);
        end
        sel = $urandom_range(0, 99);
        tgt = 24'($urandom);
        if (sel < 72) begin
          cmd = CMD_TICK;
        end else if (sel < 88) begin
          cmd = CMD_SET_TARGET;
          if ($urandom_range(0, 4) != 0)
            tgt = 24'(int'($urandom_range(0, 2 * span + 6)) - (span + 3));
        end else if (sel < 97) begin
          cmd = CMD_REZERO;
        end else begin
          cmd = CMD_UNUSED;
        end
        send_request(cmd, tgt);
      end
      drain();
    end

    if (errors == 0) begin
      $display("stepper_ramp_pulse_generator test passed");
    end else begin
      $display("stepper_ramp_pulse_generator test failed");
    end
    $finish;
  end

endmodule
